FILE: src/brle_pkg.sv
package brle_pkg;

  localparam int MAX_SEGMENT_DEF      = 128;
  localparam int BYTES_PER_RESULT_DEF = 8;

  localparam int DATA_W     = 8;
  localparam int OUT_SLOTS  = 8;
  localparam int COUNT_W    = 4;
  localparam int OUT_TDATA_W = 72;

  localparam logic [DATA_W-1:0] RUN_FLAG = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_JUDGE,
    S_FL_HDR,
    S_FL_DATA,
    S_PR_HDR,
    S_PR_BYTE,
    S_DONE
  } brle_state_t;

  typedef enum logic [1:0] {
    PH_HELD,
    PH_LAST,
    PH_FINAL
  } brle_phase_t;

endpackage

FILE: src/brle_ram.sv
module brle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/byte_rle_encoder.sv
// channel   | dir | valid/ready                  | payload
// ----------+-----+------------------------------+-------------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] source byte, tlast end of stream
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata 8 bytes + count, tuser item end,
//           |     |                              | tlast end of encoded stream
//
// a byte that extends a run or joins the literal buffer passes through accept and judge
// each written byte adds a step of its own, limited by the one-read literal memory port,
// and the done state hands the last partial result to the output register
// a literal flush writes its header then the buffered bytes, a run pair its header then the byte
// synchronous reset clears control state only, the literal memory needs no clearing pass
// input is refused until every result of the item has entered the output register;
// output stalls hold the packer and the memory read address
module byte_rle_encoder
  import brle_pkg::*;
#(
  parameter int MAX_SEGMENT      = MAX_SEGMENT_DEF,
  parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // data_byte
  input  logic                   s_axis_tlast,  // last_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_byte_0..out_byte_7, byte_count, zero pad
  output logic                   m_axis_tuser,  // step_done
  output logic                   m_axis_tlast   // stream_done
);

  localparam int AW = $clog2(MAX_SEGMENT);
  localparam int FW = $clog2(MAX_SEGMENT + 1);
  localparam int CW = $clog2(BYTES_PER_RESULT + 1);
  localparam logic [DATA_W-1:0] FULL_HDR = RUN_FLAG | DATA_W'(MAX_SEGMENT - 1);

  brle_state_t state;
  brle_phase_t phase;

  logic [DATA_W-1:0] cur_x;
  logic              cur_last;
  logic [DATA_W-1:0] held_value;
  logic              held_valid;
  logic [DATA_W-1:0] jx;
  logic              jsame;
  logic [FW-1:0]     run_length;
  logic              run_ovf;
  logic [FW-1:0]     lit_fill;
  logic              pair_req;
  logic [DATA_W-1:0] pair_hdr;
  logic [AW-1:0]     flush_idx;

  logic [DATA_W-1:0] acc [BYTES_PER_RESULT];
  logic [CW-1:0]     acc_cnt;
  logic [DATA_W-1:0] out_bytes [BYTES_PER_RESULT];
  logic [CW-1:0]     out_cnt;
  logic              out_valid;
  logic              out_step;
  logic              out_stream;

  logic [FW-1:0]     rl_inc;
  logic              j_flush;
  logic              j_pair;
  logic              j_lit;
  logic [DATA_W-1:0] j_hdr;
  logic [FW-1:0]     run_length_next;
  logic              run_ovf_next;
  logic [FW-1:0]     fill_next;

  logic              put_valid;
  logic [DATA_W-1:0] put_data;
  logic              out_free;
  logic              acc_full;
  logic              put_ok;
  logic              fin;
  logic              flush_last;
  logic              seq_end;
  logic              end_to_last;
  logic              end_to_flush;

  logic              mem_wr_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [DATA_W-1:0] mem_rd_data;

  brle_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_SEGMENT)
  ) u_lit_ram (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(lit_fill[AW-1:0]),
    .wr_data(jx),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign rl_inc        = run_length + FW'(1);

  always_comb begin
    j_flush         = 1'b0;
    j_pair          = 1'b0;
    j_lit           = 1'b0;
    j_hdr           = FULL_HDR;
    run_length_next = run_length;
    run_ovf_next    = run_ovf;
    if (jsame) begin
      run_length_next = rl_inc;
      if (rl_inc == FW'(MAX_SEGMENT)) begin
        j_flush         = (lit_fill != '0);
        j_pair          = 1'b1;
        run_length_next = '0;
        run_ovf_next    = 1'b1;
      end
    end else if (run_ovf || run_length > FW'(1)) begin
      j_flush         = (lit_fill != '0);
      j_pair          = (run_length != '0);
      j_hdr           = RUN_FLAG | (DATA_W'(run_length) - DATA_W'(1));
      run_length_next = FW'(1);
      run_ovf_next    = 1'b0;
    end else begin
      j_lit   = 1'b1;
      j_flush = ((lit_fill + FW'(1)) == FW'(MAX_SEGMENT));
    end
  end

  always_comb begin
    put_valid = 1'b0;
    put_data  = '0;
    case (state)
      S_FL_HDR: begin
        put_valid = 1'b1;
        put_data  = DATA_W'(lit_fill) - DATA_W'(1);
      end
      S_FL_DATA: begin
        put_valid = 1'b1;
        put_data  = mem_rd_data;
      end
      S_PR_HDR: begin
        put_valid = 1'b1;
        put_data  = pair_hdr;
      end
      S_PR_BYTE: begin
        put_valid = 1'b1;
        put_data  = jx;
      end
      default: begin
        put_valid = 1'b0;
      end
    endcase
  end

  assign out_free   = !out_valid || m_axis_tready;
  assign acc_full   = (acc_cnt == CW'(BYTES_PER_RESULT));
  assign put_ok     = !acc_full || out_free;
  assign fin        = (state == S_DONE) && out_free && (acc_cnt != '0);
  assign flush_last = (FW'(flush_idx) == lit_fill - FW'(1));
  assign mem_wr_en  = (state == S_JUDGE) && j_lit;

  always_comb begin
    if (state == S_FL_DATA) begin
      mem_rd_addr = put_ok ? flush_idx + AW'(1) : flush_idx;
    end else begin
      mem_rd_addr = '0;
    end
  end

  always_comb begin
    if (state == S_JUDGE && j_lit) begin
      fill_next = lit_fill + FW'(1);
    end else if (state == S_FL_DATA && put_ok && flush_last) begin
      fill_next = '0;
    end else begin
      fill_next = lit_fill;
    end
  end

  assign seq_end = ((state == S_JUDGE) && !j_flush && !j_pair) ||
                   ((state == S_FL_DATA) && put_ok && flush_last && !pair_req) ||
                   ((state == S_PR_BYTE) && put_ok);
  assign end_to_last  = (phase == PH_HELD) && cur_last;
  assign end_to_flush = (phase == PH_LAST) && (fill_next != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_HELD;
      held_valid <= 1'b0;
      run_length <= FW'(1);
      run_ovf    <= 1'b0;
      lit_fill   <= '0;
      acc_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      lit_fill <= fill_next;

      // output register
      if ((put_valid && put_ok && acc_full) || fin) begin
        out_bytes  <= acc;
        out_cnt    <= acc_cnt;
        out_step   <= fin;
        out_stream <= fin && cur_last;
        out_valid  <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      // byte packer
      if (put_valid && put_ok) begin
        if (acc_full) begin
          acc[0]  <= put_data;
          acc_cnt <= CW'(1);
        end else begin
          for (int j = 0; j < BYTES_PER_RESULT; j++) begin
            if (acc_cnt == CW'(j)) begin
              acc[j] <= put_data;
            end
          end
          acc_cnt <= acc_cnt + CW'(1);
        end
      end else if (fin) begin
        acc_cnt <= '0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cur_x      <= s_axis_tdata;
            cur_last   <= s_axis_tlast;
            held_value <= s_axis_tdata;
            held_valid <= !s_axis_tlast;
            if (held_valid) begin
              jx    <= held_value;
              jsame <= (held_value == s_axis_tdata);
              phase <= PH_HELD;
              state <= S_JUDGE;
            end else if (s_axis_tlast) begin
              jx    <= s_axis_tdata;
              jsame <= 1'b0;
              phase <= PH_LAST;
              state <= S_JUDGE;
            end
          end
        end
        S_JUDGE: begin
          run_length <= run_length_next;
          run_ovf    <= run_ovf_next;
          pair_req   <= j_pair;
          pair_hdr   <= j_hdr;
          if (j_flush) begin
            state <= S_FL_HDR;
          end else if (j_pair) begin
            state <= S_PR_HDR;
          end
        end
        S_FL_HDR: begin
          flush_idx <= '0;
          if (put_ok) begin
            state <= S_FL_DATA;
          end
        end
        S_FL_DATA: begin
          if (put_ok) begin
            flush_idx <= flush_idx + AW'(1);
            if (flush_last && pair_req) begin
              state <= S_PR_HDR;
            end
          end
        end
        S_PR_HDR: begin
          if (put_ok) begin
            state <= S_PR_BYTE;
          end
        end
        S_PR_BYTE: begin
          // left through the end-of-sequence logic below
        end
        S_DONE: begin
          if (acc_cnt == '0 || out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // end of one judge and its writes
      if (seq_end) begin
        if (end_to_last) begin
          phase <= PH_LAST;
          jx    <= cur_x;
          jsame <= 1'b0;
          state <= S_JUDGE;
        end else if (end_to_flush) begin
          phase <= PH_FINAL;
          state <= S_FL_HDR;
        end else if (state == S_JUDGE && acc_cnt == '0) begin
          state <= S_IDLE;
        end else begin
          state <= S_DONE;
        end
      end
    end
  end

  for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_out
    if (g < BYTES_PER_RESULT) begin : g_used
      assign m_axis_tdata[g*DATA_W +: DATA_W] =
        (CW'(g) < out_cnt) ? out_bytes[g] : '0;
    end else begin : g_unused
      assign m_axis_tdata[g*DATA_W +: DATA_W] = '0;
    end
  end

  assign m_axis_tdata[OUT_SLOTS*DATA_W +: COUNT_W] = COUNT_W'(out_cnt);
  assign m_axis_tdata[OUT_TDATA_W-1:OUT_SLOTS*DATA_W+COUNT_W] = '0;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_step;
  assign m_axis_tlast  = out_stream;

`ifndef SYNTHESIS
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    acc_cnt <= CW'(BYTES_PER_RESULT))
    else $error("packer count beyond result width");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> acc_cnt == '0)
    else $error("bytes left in packer while taking a new item");

  a_out_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_cnt != '0)
    else $error("empty result presented");

  a_run_range: assert property (@(posedge clk) disable iff (rst)
    run_length < FW'(MAX_SEGMENT))
    else $error("run length reached a full segment without a write");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    lit_fill <= FW'(MAX_SEGMENT))
    else $error("literal buffer overfilled");

  a_full_flushes: assert property (@(posedge clk) disable iff (rst)
    (state == S_JUDGE && j_lit && j_flush) |=> state == S_FL_HDR)
    else $error("full literal buffer not flushed");
`endif

endmodule
